FILE: rtl/nntt_pkg.sv
// Shared constants and types for the nearest-neighbor target tracker.
package nntt_pkg;

    localparam int TRACK_DEPTH = 30;
    localparam int PIXEL_BITS  = 12;

    localparam int CEN_W   = PIXEL_BITS + 1;
    localparam int RANGE_W = 26;
    localparam int DOFF_W  = RANGE_W + 1;
    localparam int IDX_W   = $clog2(TRACK_DEPTH);
    localparam int CNT_W   = $clog2(TRACK_DEPTH + 1);
    localparam int SUM_W   = CNT_W + 1;
    localparam int MISS_W  = 6;
    localparam int SQ_W    = 2 * RANGE_W;
    localparam int DIST_W  = SQ_W + 1;
    localparam int DIVC_W  = $clog2(RANGE_W);

    localparam int FOCAL_W  = 16;
    localparam int OBJW_W   = 10;
    localparam int LIMIT_W  = 5;
    localparam int ORIGIN_W = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int IN_FIELDS_W  = 4 * PIXEL_BITS;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 2 * CEN_W + RANGE_W + DOFF_W + CNT_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TUSER_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_FOCAL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OBJW   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN = 2'd3;

    localparam logic [FOCAL_W-1:0]  FOCAL_RST  = 16'd800;
    localparam logic [OBJW_W-1:0]   OBJW_RST   = 10'd150;
    localparam logic [LIMIT_W-1:0]  LIMIT_RST  = 5'd15;
    localparam logic [ORIGIN_W-1:0] ORIGIN_RST = 16'd500;

    localparam logic [MISS_W-1:0] MISS_SAT = '1;

    typedef struct packed {
        logic [CEN_W-1:0]   cx;
        logic [CEN_W-1:0]   cy;
        logic [RANGE_W-1:0] rng;
    } track_pt_t;

endpackage

FILE: rtl/nearest_neighbor_target_tracker.sv
// Nearest-neighbor target tracker: range divider, distance unit, trajectory memory.
// A box beat passes the accept state, the 26-step restoring range divider, three
// squaring states on the shared multiplier and a compare; if it closes the frame,
// frame end follows. A no-detection beat goes straight to frame end, which waits
// for a free output register. Async active-low reset clears control and loads
// register defaults; the trajectory memory is not cleared, only counted entries are used.
module nearest_neighbor_target_tracker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [nntt_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [nntt_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // box_x, box_y, box_width, box_height
    input  logic [nntt_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // cmd
    input  logic                                  s_axis_tuser,
    input  logic                                  s_axis_tlast,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // center_x, center_y, range_mm, depth_offset, track_length, zero pad
    output logic [nntt_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // position_valid, no_target
    output logic [nntt_pkg::OUT_TUSER_W-1:0]      m_axis_tuser
);
    import nntt_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_DIV  = 7'b0000010,
        S_SQX  = 7'b0000100,
        S_SQY  = 7'b0001000,
        S_SQR  = 7'b0010000,
        S_CMP  = 7'b0100000,
        S_END  = 7'b1000000
    } state_t;

    state_t state_reg;

    logic [FOCAL_W-1:0]  focal_reg;
    logic [OBJW_W-1:0]   objw_reg;
    logic [LIMIT_W-1:0]  limit_reg;
    logic [ORIGIN_W-1:0] origin_reg;

    logic [IDX_W-1:0]  head_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [MISS_W-1:0] miss_reg;
    logic [1:0]        hits_reg;
    logic              missed_reg;
    logic              last_reg;

    track_pt_t         best_reg;
    logic [DIST_W-1:0] best_sq_reg;
    track_pt_t         mem_rd_reg;
    logic [CEN_W-1:0]  cand_cx_reg;
    logic [CEN_W-1:0]  cand_cy_reg;

    logic [RANGE_W-1:0]    div_q_reg;
    logic [PIXEL_BITS-1:0] div_rem_reg;
    logic [PIXEL_BITS-1:0] div_dvs_reg;
    logic [DIVC_W-1:0]     div_cnt_reg;

    logic [SQ_W-1:0]   sq_reg;
    logic [DIST_W-1:0] acc_reg;

    logic                         m_valid_reg;
    logic [OUT_TDATA_W-1:0]       m_data_reg;
    logic [OUT_TUSER_W-1:0]       m_user_reg;

    track_pt_t traj_mem [TRACK_DEPTH];

    // input field unpacking
    logic [PIXEL_BITS-1:0] in_x, in_y, in_w, in_h;
    assign in_x = s_axis_tdata[PIXEL_BITS-1:0];
    assign in_y = s_axis_tdata[2*PIXEL_BITS-1:PIXEL_BITS];
    assign in_w = s_axis_tdata[3*PIXEL_BITS-1:2*PIXEL_BITS];
    assign in_h = s_axis_tdata[4*PIXEL_BITS-1:3*PIXEL_BITS];

    logic in_beat;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    // latest trajectory entry, valid only when count is nonzero
    logic [SUM_W-1:0] lat_sum;
    logic [IDX_W-1:0] rd_idx;
    always_comb
    begin
        lat_sum = SUM_W'(head_reg) + SUM_W'(count_reg) - SUM_W'(1);
        if (lat_sum >= SUM_W'(TRACK_DEPTH))
            rd_idx = IDX_W'(lat_sum - SUM_W'(TRACK_DEPTH));
        else
            rd_idx = IDX_W'(lat_sum);
    end

    // restoring divider step
    logic [PIXEL_BITS:0]   div_shift;
    logic                  div_ge;
    logic [PIXEL_BITS:0]   div_diff;
    always_comb
    begin
        div_shift = {div_rem_reg, div_q_reg[RANGE_W-1]};
        div_ge    = div_shift >= {1'b0, div_dvs_reg};
        div_diff  = div_shift - {1'b0, div_dvs_reg};
    end

    // shared squaring multiplier operand
    logic [RANGE_W-1:0] mul_op;
    always_comb
    begin
        case (state_reg)
            S_SQX:
                mul_op = (cand_cx_reg >= mem_rd_reg.cx) ?
                         RANGE_W'(cand_cx_reg - mem_rd_reg.cx) :
                         RANGE_W'(mem_rd_reg.cx - cand_cx_reg);
            S_SQY:
                mul_op = (cand_cy_reg >= mem_rd_reg.cy) ?
                         RANGE_W'(cand_cy_reg - mem_rd_reg.cy) :
                         RANGE_W'(mem_rd_reg.cy - cand_cy_reg);
            default:
                mul_op = (div_q_reg >= mem_rd_reg.rng) ?
                         (div_q_reg - mem_rd_reg.rng) : (mem_rd_reg.rng - div_q_reg);
        endcase
    end

    logic [DIST_W-1:0] cand_dist;
    assign cand_dist = acc_reg + DIST_W'(sq_reg);

    // frame-end bookkeeping
    logic              end_go;
    logic [IDX_W-1:0]  head1;
    logic [CNT_W-1:0]  count1;
    logic              append;
    logic [SUM_W-1:0]  wr_sum;
    logic [IDX_W-1:0]  wr_idx;
    logic [MISS_W-1:0] miss_next;
    logic              clear;
    logic [IDX_W-1:0]  head_next;
    logic [CNT_W-1:0]  count_next;
    logic              pos_valid;
    logic [DOFF_W-1:0] doff;

    always_comb
    begin
        end_go = (state_reg == S_END) && (!m_valid_reg || m_axis_tready);
        // drop the oldest point at capacity
        if (count_reg >= CNT_W'(TRACK_DEPTH))
        begin
            head1  = (head_reg == IDX_W'(TRACK_DEPTH - 1)) ? '0 : head_reg + IDX_W'(1);
            count1 = CNT_W'(TRACK_DEPTH - 1);
        end
        else
        begin
            head1  = head_reg;
            count1 = count_reg;
        end
        append = !missed_reg && ((hits_reg == 2'd1) || (count1 != '0));
        wr_sum = SUM_W'(head1) + SUM_W'(count1);
        if (wr_sum >= SUM_W'(TRACK_DEPTH))
            wr_idx = IDX_W'(wr_sum - SUM_W'(TRACK_DEPTH));
        else
            wr_idx = IDX_W'(wr_sum);
        if (missed_reg)
            miss_next = (miss_reg == MISS_SAT) ? miss_reg : miss_reg + MISS_W'(1);
        else
            miss_next = '0;
        clear      = miss_next > MISS_W'(limit_reg);
        head_next  = clear ? '0 : head1;
        count_next = clear ? '0 : (append ? count1 + CNT_W'(1) : count1);
        pos_valid  = !missed_reg && (count_next != '0);
        doff       = {1'b0, best_reg.rng} - DOFF_W'(origin_reg);
    end

    // trajectory memory: read at every accepted beat, write at frame end, never both at once
    always_ff @(posedge clk)
    begin
        if (end_go && append)
            traj_mem[wr_idx] <= best_reg;
        if (in_beat)
            mem_rd_reg <= traj_mem[rd_idx];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            focal_reg   <= FOCAL_RST;
            objw_reg    <= OBJW_RST;
            limit_reg   <= LIMIT_RST;
            origin_reg  <= ORIGIN_RST;
            head_reg    <= '0;
            count_reg   <= '0;
            miss_reg    <= '0;
            hits_reg    <= '0;
            best_reg    <= '0;
            best_sq_reg <= '0;
            missed_reg  <= 1'b0;
            last_reg    <= 1'b0;
            div_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_FOCAL:  focal_reg  <= cfg_wdata[FOCAL_W-1:0];
                    REG_OBJW:   objw_reg   <= cfg_wdata[OBJW_W-1:0];
                    REG_LIMIT:  limit_reg  <= cfg_wdata[LIMIT_W-1:0];
                    REG_ORIGIN: origin_reg <= cfg_wdata[ORIGIN_W-1:0];
                    default:    ;
                endcase
            end

            if (end_go)
                m_valid_reg <= 1'b1;
            else if (m_valid_reg && m_axis_tready)
                m_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_beat)
                    begin
                        missed_reg  <= s_axis_tuser;
                        last_reg    <= s_axis_tlast;
                        div_cnt_reg <= '0;
                        state_reg   <= s_axis_tuser ? S_END : S_DIV;
                    end
                end
                S_DIV:
                begin
                    div_cnt_reg <= div_cnt_reg + DIVC_W'(1);
                    if (div_cnt_reg == DIVC_W'(RANGE_W - 1))
                        state_reg <= S_SQX;
                end
                S_SQX:   state_reg <= S_SQY;
                S_SQY:   state_reg <= S_SQR;
                S_SQR:   state_reg <= S_CMP;
                S_CMP:
                begin
                    if (hits_reg == 2'd0)
                    begin
                        best_reg <= '{cx: cand_cx_reg, cy: cand_cy_reg, rng: div_q_reg};
                        if (count_reg != '0)
                            best_sq_reg <= cand_dist;
                    end
                    else if ((count_reg != '0) && (cand_dist <= best_sq_reg))
                    begin
                        best_reg    <= '{cx: cand_cx_reg, cy: cand_cy_reg, rng: div_q_reg};
                        best_sq_reg <= cand_dist;
                    end
                    if (hits_reg != 2'd2)
                        hits_reg <= hits_reg + 2'd1;
                    state_reg <= last_reg ? S_END : S_IDLE;
                end
                S_END:
                begin
                    // hold until the output register is free
                    if (end_go)
                    begin
                        head_reg    <= head_next;
                        count_reg   <= count_next;
                        miss_reg    <= miss_next;
                        hits_reg    <= '0;
                        best_reg    <= '0;
                        best_sq_reg <= '0;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            cand_cx_reg <= CEN_W'(in_x) + CEN_W'(in_w[PIXEL_BITS-1:1]);
            cand_cy_reg <= CEN_W'(in_y) + CEN_W'(in_h[PIXEL_BITS-1:1]);
            div_q_reg   <= RANGE_W'(focal_reg) * RANGE_W'(objw_reg);
            div_rem_reg <= '0;
            div_dvs_reg <= in_w;
        end
        else if (state_reg == S_DIV)
        begin
            div_q_reg   <= {div_q_reg[RANGE_W-2:0], div_ge};
            div_rem_reg <= div_ge ? div_diff[PIXEL_BITS-1:0] : div_shift[PIXEL_BITS-1:0];
        end

        if ((state_reg == S_SQX) || (state_reg == S_SQY) || (state_reg == S_SQR))
            sq_reg <= mul_op * mul_op;
        if (state_reg == S_SQY)
            acc_reg <= DIST_W'(sq_reg);
        else if (state_reg == S_SQR)
            acc_reg <= acc_reg + DIST_W'(sq_reg);

        if (end_go)
        begin
            m_user_reg <= {missed_reg, pos_valid};
            m_data_reg <= OUT_TDATA_W'({count_next,
                                        pos_valid ? doff : DOFF_W'(0),
                                        pos_valid ? best_reg.rng : RANGE_W'(0),
                                        pos_valid ? best_reg.cy : CEN_W'(0),
                                        pos_valid ? best_reg.cx : CEN_W'(0)});
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TRACK_DEPTH))
        else $error("track count beyond depth");

    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg < IDX_W'(TRACK_DEPTH))
        else $error("track head out of range");

    a_miss_to_end: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser) |=> (state_reg == S_END))
        else $error("missed frame did not go to frame end");

    a_valid_len: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_user_reg[0]) |-> (count_reg != '0) && !m_user_reg[1])
        else $error("reported position with empty track or missed frame");

endmodule

FILE: bench/tb.sv
// Self-checking stream testbench for the nearest-neighbor target tracker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nntt_pkg::*;

    localparam int CY_LO   = CEN_W;
    localparam int RNG_LO  = 2 * CEN_W;
    localparam int DOFF_LO = RNG_LO + RANGE_W;
    localparam int TLEN_LO = DOFF_LO + DOFF_W;
    localparam int SETTLE_CYCLES = 64;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 150;
    localparam logic [RANGE_W-1:0] RANGE_SAT = '1;

    typedef logic [PIXEL_BITS-1:0] pix_t;

    typedef struct packed {
        logic               pos_valid;
        logic               no_target;
        logic [CEN_W-1:0]   cx;
        logic [CEN_W-1:0]   cy;
        logic [RANGE_W-1:0] rng;
        logic [DOFF_W-1:0]  doff;
        logic [CNT_W-1:0]   tlen;
    } position_t;

    class track_scoreboard;
        track_pt_t          path [TRACK_DEPTH];
        int unsigned        head;
        int unsigned        count;
        int unsigned        misses;
        int unsigned        hits;
        track_pt_t          best;
        logic [63:0]        best_dist;
        logic [FOCAL_W-1:0] focal;
        logic [OBJW_W-1:0]  objw;
        logic [LIMIT_W-1:0] limit;
        logic [ORIGIN_W-1:0] origin;
        position_t          position_q [$];
        int                 errors;
        int                 positions_checked;
        int                 boxes;
        int                 frames;
        int                 frames_valid;
        int                 frames_missed;
        int                 clears;
        int                 full_drops;

        function new();
            head = 0;
            count = 0;
            misses = 0;
            hits = 0;
            best = '0;
            best_dist = '0;
            focal = FOCAL_RST;
            objw = OBJW_RST;
            limit = LIMIT_RST;
            origin = ORIGIN_RST;
            errors = 0;
            positions_checked = 0;
            boxes = 0;
            frames = 0;
            frames_valid = 0;
            frames_missed = 0;
            clears = 0;
            full_drops = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_FOCAL:  focal = val[FOCAL_W-1:0];
                REG_OBJW:   objw = val[OBJW_W-1:0];
                REG_LIMIT:  limit = val[LIMIT_W-1:0];
                REG_ORIGIN: origin = val[ORIGIN_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return position_q.size();
        endfunction

        function logic [63:0] sq_gap(logic [63:0] a, logic [63:0] b);
            logic [63:0] d;
            d = (a > b) ? (a - b) : (b - a);
            return d * d;
        endfunction

        function track_pt_t latest();
            return path[(head + count - 1) % TRACK_DEPTH];
        endfunction

        function logic [63:0] dist_to_latest(track_pt_t p);
            track_pt_t q;
            q = latest();
            return sq_gap(64'(p.cx), 64'(q.cx)) + sq_gap(64'(p.cy), 64'(q.cy))
                 + sq_gap(64'(p.rng), 64'(q.rng));
        endfunction

        // Fold one accepted beat into the open frame; close the frame when it ends.
        function void take_detection(logic cmd, logic [IN_TDATA_W-1:0] data, logic closes);
            pix_t        bx;
            pix_t        by;
            pix_t        bw;
            pix_t        bh;
            track_pt_t   p;
            track_pt_t   q;
            logic [63:0] prod;
            logic [63:0] d;
            position_t   r;
            bx = data[0 +: PIXEL_BITS];
            by = data[PIXEL_BITS +: PIXEL_BITS];
            bw = data[2 * PIXEL_BITS +: PIXEL_BITS];
            bh = data[3 * PIXEL_BITS +: PIXEL_BITS];
            if (!cmd) begin
                boxes++;
                p.cx = CEN_W'(bx) + CEN_W'(bw >> 1);
                p.cy = CEN_W'(by) + CEN_W'(bh >> 1);
                prod = 64'(focal);
                prod = prod * 64'(objw);
                if (bw == 0) begin
                    p.rng = RANGE_SAT;
                end
                else begin
                    prod = prod / 64'(bw);
                    p.rng = (prod > 64'(RANGE_SAT)) ? RANGE_SAT : prod[RANGE_W-1:0];
                end
                if (hits == 0) begin
                    best = p;
                    if (count > 0)
                        best_dist = dist_to_latest(p);
                end
                else if (count > 0) begin
                    // ties go to the later box
                    d = dist_to_latest(p);
                    if (d <= best_dist) begin
                        best_dist = d;
                        best = p;
                    end
                end
                if (hits < 2)
                    hits++;
                if (!closes)
                    return;
            end

            frames++;
            if (count >= TRACK_DEPTH) begin
                head = (head + 1) % TRACK_DEPTH;
                count = TRACK_DEPTH - 1;
                full_drops++;
            end
            if (cmd) begin
                frames_missed++;
                if (misses < MISS_SAT)
                    misses++;
            end
            else begin
                misses = 0;
                if (hits == 1 || count > 0) begin
                    path[(head + count) % TRACK_DEPTH] = best;
                    count++;
                end
            end
            if (misses > limit) begin
                if (count > 0)
                    clears++;
                head = 0;
                count = 0;
            end
            r = '0;
            r.no_target = cmd;
            r.tlen = CNT_W'(count);
            if (!cmd && count > 0) begin
                frames_valid++;
                q = latest();
                r.pos_valid = 1'b1;
                r.cx = q.cx;
                r.cy = q.cy;
                r.rng = q.rng;
                r.doff = DOFF_W'(q.rng);
                r.doff = r.doff - DOFF_W'(origin);
            end
            position_q = {position_q, r};
            hits = 0;
            best = '0;
            best_dist = '0;
        endfunction

        task report(string msg);
            $display("[%0t] ERROR position %0d: %s", $time, positions_checked, msg);
            errors++;
        endtask

        task compare(string field, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                report($sformatf("%s is 0x%0h, wanted 0x%0h", field, got, want));
        endtask

        task check_position(logic [OUT_TDATA_W-1:0] tdata, logic [OUT_TUSER_W-1:0] tuser);
            position_t w;
            positions_checked++;
            if (position_q.size() == 0) begin
                report("beat arrived with nothing outstanding");
                return;
            end
            w = position_q.pop_front();
            compare("position_valid", 64'(tuser[0]), 64'(w.pos_valid));
            compare("no_target", 64'(tuser[1]), 64'(w.no_target));
            compare("center_x", 64'(tdata[0 +: CEN_W]), 64'(w.cx));
            compare("center_y", 64'(tdata[CY_LO +: CEN_W]), 64'(w.cy));
            compare("range_mm", 64'(tdata[RNG_LO +: RANGE_W]), 64'(w.rng));
            compare("depth_offset", 64'(tdata[DOFF_LO +: DOFF_W]), 64'(w.doff));
            compare("track_length", 64'(tdata[TLEN_LO +: CNT_W]), 64'(w.tlen));
        endtask
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_wdata;
    logic                       s_axis_tvalid;
    logic                       s_axis_tready;
    logic [IN_TDATA_W-1:0]      s_axis_tdata;
    logic                       s_axis_tuser;
    logic                       s_axis_tlast;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready;
    logic [OUT_TDATA_W-1:0]     m_axis_tdata;
    logic [OUT_TUSER_W-1:0]     m_axis_tuser;

    track_scoreboard sb;
    logic            sender_calm;
    logic            sink_calm;
    int              items_sent;
    int              settings_used;
    pix_t            tgt_x;
    pix_t            tgt_y;
    pix_t            tgt_w;

    nearest_neighbor_target_tracker dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    task automatic offer(logic cmd, logic [IN_TDATA_W-1:0] data, logic closes);
        int gap;
        gap = sender_calm ? 0 : pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= data;
        s_axis_tuser <= cmd;
        s_axis_tlast <= closes;
        do
            @(posedge clk);
        while (s_axis_tready !== 1'b1);
        sb.take_detection(cmd, data, closes);
        items_sent++;
    endtask

    task automatic send_box(pix_t x, pix_t y, pix_t w, pix_t h, logic closes);
        offer(1'b0, {h, w, y, x}, closes);
    endtask

    // box fields of a no-detection beat are ignored, so fill them with noise
    task automatic send_miss();
        offer(1'b1, IN_TDATA_W'({$urandom, $urandom}), 1'($urandom_range(0, 1)));
    endtask

    task automatic program_regs(logic [CFG_DATA_W-1:0] focal, logic [CFG_DATA_W-1:0] objw,
                                logic [CFG_DATA_W-1:0] limit, logic [CFG_DATA_W-1:0] origin);
        logic [CFG_IDX_W-1:0] idx [4];
        logic [CFG_DATA_W-1:0] val [4];
        idx = '{REG_FOCAL, REG_OBJW, REG_LIMIT, REG_ORIGIN};
        val = '{focal, objw, limit, origin};
        for (int i = 0; i < 4; i++)
        begin
            @(negedge clk);
            cfg_we <= 1'b1;
            cfg_index <= idx[i];
            cfg_wdata <= val[i];
            sb.set_register(idx[i], val[i]);
        end
        @(negedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Drop valid, let every outstanding position arrive, then let the divider settle.
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_box(logic closes);
        int   roll;
        pix_t x;
        pix_t y;
        pix_t w;
        pix_t h;
        roll = $urandom_range(0, 9);
        x = pix_t'($urandom);
        y = pix_t'($urandom);
        w = pix_t'($urandom);
        h = pix_t'($urandom);
        if (roll < 6) begin
            // near the drifting target, so the nearest-box choice matters
            x = tgt_x + pix_t'($urandom_range(0, 24)) - pix_t'(12);
            y = tgt_y + pix_t'($urandom_range(0, 24)) - pix_t'(12);
            w = tgt_w + pix_t'($urandom_range(0, 8)) - pix_t'(4);
        end
        else if (roll == 9) begin
            case ($urandom_range(0, 2))
                0: w = '0;
                1: w = pix_t'(1);
                default: w = '1;
            endcase
        end
        send_box(x, y, w, h, closes);
    endtask

    task automatic run_traffic(int n_items);
        int start;
        int roll;
        int n;
        start = items_sent;
        while (items_sent - start < n_items)
        begin
            roll = $urandom_range(0, 99);
            tgt_x = tgt_x + pix_t'($urandom_range(0, 16)) - pix_t'(8);
            tgt_y = tgt_y + pix_t'($urandom_range(0, 16)) - pix_t'(8);
            tgt_w = tgt_w + pix_t'($urandom_range(0, 6)) - pix_t'(3);
            if (tgt_w < 8 || tgt_w > 600)
                tgt_w = pix_t'($urandom_range(16, 400));
            if (roll < 12) begin
                send_miss();
            end
            else if (roll < 14) begin
                repeat ($urandom_range(2, 36)) send_miss();
            end
            else if (roll < 19) begin
                // broken frame: boxes cut short by a no-detection beat
                repeat ($urandom_range(1, 3)) random_box(1'b0);
                send_miss();
            end
            else begin
                n = $urandom_range(0, 1) ? 1 : $urandom_range(2, 4);
                for (int i = 0; i < n; i++)
                    random_box(i == n - 1);
            end
        end
    endtask

    initial
    begin : sink
        int  idle;
        bit  long_hold_done;
        idle = 0;
        long_hold_done = 0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
                sb.check_position(m_axis_tdata, m_axis_tuser);
                if (!long_hold_done && sb.positions_checked >= 60) begin
                    // long hold-off: let the block fill up and stall its input
                    idle = 600;
                    long_hold_done = 1;
                end
                else if (!sink_calm) begin
                    idle = pick_gap();
                end
            end
            @(negedge clk);
            if (idle == 0 && !sink_calm && $urandom_range(0, 15) == 0)
                idle = pick_gap();
            if (idle > 0) begin
                m_axis_tready <= 1'b0;
                idle--;
            end
            else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial
    begin : watchdog
        #3_000_000;
        $display("timeout with %0d positions outstanding", sb.pending());
        $display("** nearest_neighbor_target_tracker: FAILED **");
        $finish;
    end

    initial
    begin : stimulus
        sb = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_FOCAL;
        cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        sender_calm = 1'b1;
        sink_calm = 1'b0;
        items_sent = 0;
        settings_used = 0;
        tgt_x = 12'd1500;
        tgt_y = 12'd900;
        tgt_w = 12'd120;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        program_regs(CFG_DATA_W'(FOCAL_RST), CFG_DATA_W'(OBJW_RST),
                     CFG_DATA_W'(LIMIT_RST), CFG_DATA_W'(ORIGIN_RST));

        // several boxes with an empty trajectory: nothing appended
        send_box(12'd100, 12'd200, 12'd40, 12'd30, 1'b0);
        send_box(12'd120, 12'd210, 12'd44, 12'd32, 1'b1);
        send_box(12'd1000, 12'd1000, 12'd100, 12'd100, 1'b1);
        // equal distance on both sides of the latest point: later box wins
        send_box(12'd990, 12'd1000, 12'd100, 12'd100, 1'b0);
        send_box(12'd1010, 12'd1000, 12'd100, 12'd100, 1'b1);
        send_box(12'd1200, 12'd1000, 12'd100, 12'd100, 1'b0);
        send_box(12'd1015, 12'd1002, 12'd100, 12'd100, 1'b0);
        send_box(12'd1300, 12'd900, 12'd90, 12'd100, 1'b1);
        send_box('1, '1, '1, '1, 1'b1);
        // zero width saturates the range
        send_box('0, '0, '0, '0, 1'b1);
        send_box('0, '0, 12'd1, 12'd1, 1'b1);
        // no-detection beat mid-frame discards the collected boxes
        send_box(12'd500, 12'd500, 12'd64, 12'd64, 1'b0);
        send_miss();
        send_miss();
        send_box(12'd2048, 12'd1024, 12'd2048, 12'd0, 1'b1);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph > 0) begin
                drain();
                case (ph)
                    1: program_regs(16'd65535, 16'd1023, 16'd0, 16'd0);
                    2: program_regs(16'd1, 16'd1, 16'd31, 16'd65535);
                    4: program_regs(16'd65535, 16'd1, 16'd31, 16'd0);
                    5: program_regs(16'd1, 16'd1023, 16'd0, 16'd65535);
                    7: program_regs(CFG_DATA_W'(FOCAL_RST), CFG_DATA_W'(OBJW_RST),
                                    CFG_DATA_W'(LIMIT_RST), CFG_DATA_W'(ORIGIN_RST));
                    default: program_regs(CFG_DATA_W'($urandom_range(1, 65535)),
                                          CFG_DATA_W'($urandom_range(1, 1023)),
                                          CFG_DATA_W'($urandom_range(0, 31)),
                                          CFG_DATA_W'($urandom_range(0, 65535)));
                endcase
            end
            sender_calm = (ph == 3 || ph == 7);
            sink_calm = (ph == 5 || ph == 7);
            run_traffic(PHASE_ITEMS);
        end

        drain();
        $display("covered %0d beats, %0d boxes, %0d frames (%0d with a position, %0d missed)",
                 items_sent, sb.boxes, sb.frames, sb.frames_valid, sb.frames_missed);
        $display("%0d register settings, %0d trajectory clears, %0d full-depth drops, %0d errors",
                 settings_used, sb.clears, sb.full_drops, sb.errors);
        if (sb.errors == 0)
            $display("** nearest_neighbor_target_tracker: PASSED **");
        else
            $display("** nearest_neighbor_target_tracker: FAILED **");
        $finish;
    end
endmodule

FILE: filelist.f
rtl/nntt_pkg.sv
rtl/nearest_neighbor_target_tracker.sv
bench/tb.sv
